[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands for the RTL; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

[rtl/core/iee_pkg.sv]
// ----------------------------------------------------------------------------
// iee_pkg
// Shared codes and controller/datapath interface types for the evaluator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package iee_pkg;

    localparam logic [2:0] OPR_ADD = 3'd0;
    localparam logic [2:0] OPR_SUB = 3'd1;
    localparam logic [2:0] OPR_MUL = 3'd2;
    localparam logic [2:0] OPR_DIV = 3'd3;

    localparam logic [1:0] PEND_POS = 2'd0;
    localparam logic [1:0] PEND_NEG = 2'd1;
    localparam logic [1:0] PEND_MUL = 2'd2;
    localparam logic [1:0] PEND_DIV = 2'd3;

    localparam int OPND_WIDTH = 31;
    localparam int OUT_WIDTH  = 32;

    typedef struct packed {
        logic start;
        logic step;
        logic finish;
    } t_iee_cmd;

    typedef struct packed {
        logic iter_needed;
        logic is_eq;
        logic out_free;
    } t_iee_sts;

endpackage

`default_nettype wire

[rtl/core/iee_ctrl.sv]
// ----------------------------------------------------------------------------
// iee_ctrl
// Sequencer: accept a word, run the shift-add / restoring-divide iterations,
// then commit the term and emit on equals.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module iee_ctrl #(
    parameter int DATA_WIDTH = 32
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_stall,
    input  iee_pkg::t_iee_sts i_sts,
    output iee_pkg::t_iee_cmd o_cmd
);
    import iee_pkg::*;

    localparam int CW = $clog2(DATA_WIDTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ITER,
        S_FIN
    } t_state;

    t_state         r_state;
    logic [CW-1:0]  r_cnt;
    logic           r_in_stall;
    logic           last_step;

    assign o_in_stall = r_in_stall;
    assign last_step  = (r_cnt == CW'(DATA_WIDTH - 1));

    always_comb begin
        o_cmd        = '0;
        o_cmd.start  = (r_state == S_IDLE) && i_in_valid;
        o_cmd.step   = (r_state == S_ITER) && i_sts.iter_needed;
        o_cmd.finish = (r_state == S_FIN) && (!i_sts.is_eq || i_sts.out_free);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cnt      <= '0;
            r_in_stall <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state    <= S_ITER;
                        r_cnt      <= '0;
                        r_in_stall <= 1'b1;
                    end
                end
                S_ITER: begin
                    if (!i_sts.iter_needed || last_step) begin
                        r_state <= S_FIN;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_FIN: begin
                    if (o_cmd.finish) begin
                        r_state    <= S_IDLE;
                        r_in_stall <= 1'b0;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `ASSERT_NXT(a_accept_iter, i_clk, i_rst_n, o_cmd.start, r_state == S_ITER)
    `ASSERT_IMP(a_step_bound, i_clk, i_rst_n, o_cmd.step, r_cnt < CW'(DATA_WIDTH))
    `ASSERT_IMP(a_stall_busy, i_clk, i_rst_n, r_state != S_IDLE, o_in_stall)
    `ASSERT_NXT(a_fin_idle, i_clk, i_rst_n, o_cmd.finish, r_state == S_IDLE && !o_in_stall)

endmodule

`default_nettype wire

[rtl/core/iee_dpath.sv]
// ----------------------------------------------------------------------------
// iee_dpath
// Sum/term accumulators, shared shift-add multiplier and restoring divider,
// and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module iee_dpath #(
    parameter int DATA_WIDTH = 32
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire [iee_pkg::OPND_WIDTH-1:0]         i_operand,
    input  wire [2:0]                             i_opr,
    input  iee_pkg::t_iee_cmd                     i_cmd,
    output iee_pkg::t_iee_sts                     o_sts,
    output logic                                  o_out_valid,
    input  wire                                   i_out_stall,
    output logic signed [iee_pkg::OUT_WIDTH-1:0]  o_value,
    output logic                                  o_div_zero
);
    import iee_pkg::*;

    localparam int DW = DATA_WIDTH;
    localparam int XW = (DW < OPND_WIDTH) ? DW : OPND_WIDTH;

    logic [DW-1:0] r_sum, r_term, r_x, r_acc, r_sh, r_mc;
    logic [1:0]    r_pend;
    logic [2:0]    r_op;
    logic          r_err, r_neg;

    logic [DW-1:0]        x_in, term_mag, term_new, sum_new;
    logic signed [DW-1:0] v_fin;
    logic [DW:0]          rem_sh, diff;
    logic                 x_zero, err_new;

    assign x_in     = DW'(i_operand[XW-1:0]);
    assign term_mag = r_term[DW-1] ? -r_term : r_term;
    assign x_zero   = (r_x == '0);
    assign rem_sh   = {r_acc, r_sh[DW-1]};
    assign diff     = rem_sh - {1'b0, r_x};

    assign o_sts.iter_needed = (r_pend == PEND_MUL) || ((r_pend == PEND_DIV) && !x_zero);
    assign o_sts.is_eq       = (r_op != OPR_ADD) && (r_op != OPR_SUB)
                               && (r_op != OPR_MUL) && (r_op != OPR_DIV);
    assign o_sts.out_free    = !o_out_valid || !i_out_stall;

    always_comb begin
        unique case (r_pend)
            PEND_POS: term_new = r_x;
            PEND_NEG: term_new = -r_x;
            PEND_MUL: term_new = r_acc;
            default:  term_new = x_zero ? '0 : (r_neg ? -r_sh : r_sh);
        endcase
        err_new = r_err | ((r_pend == PEND_DIV) && x_zero);
        sum_new = r_sum + term_new;
        v_fin   = sum_new;
    end

    // iteration registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_x   <= x_in;
            r_op  <= i_opr;
            r_acc <= '0;
            r_mc  <= x_in;
            r_neg <= r_term[DW-1];
            r_sh  <= (r_pend == PEND_MUL) ? r_term : term_mag;
        end else if (i_cmd.step) begin
            if (r_pend == PEND_MUL) begin
                if (r_sh[0]) begin
                    r_acc <= r_acc + r_mc;
                end
                r_mc <= {r_mc[DW-2:0], 1'b0};
                r_sh <= {1'b0, r_sh[DW-1:1]};
            end else begin
                if (!diff[DW]) begin
                    r_acc <= diff[DW-1:0];
                end else begin
                    r_acc <= rem_sh[DW-1:0];
                end
                r_sh <= {r_sh[DW-2:0], !diff[DW]};
            end
        end
    end

    // expression state and result word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_term      <= '0;
            r_pend      <= PEND_POS;
            r_err       <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cmd.finish && o_sts.is_eq) begin
                o_out_valid <= 1'b1;
            end else if (o_out_valid && !i_out_stall) begin
                o_out_valid <= 1'b0;
            end
            if (i_cmd.finish) begin
                r_term <= o_sts.is_eq ? '0 : term_new;
                r_err  <= o_sts.is_eq ? 1'b0 : err_new;
                unique case (r_op)
                    OPR_ADD: begin
                        r_sum  <= sum_new;
                        r_pend <= PEND_POS;
                    end
                    OPR_SUB: begin
                        r_sum  <= sum_new;
                        r_pend <= PEND_NEG;
                    end
                    OPR_MUL: r_pend <= PEND_MUL;
                    OPR_DIV: r_pend <= PEND_DIV;
                    default: begin
                        o_value    <= OUT_WIDTH'(v_fin);
                        o_div_zero <= err_new;
                        r_sum      <= '0;
                        r_pend     <= PEND_POS;
                    end
                endcase
            end
        end
    end

endmodule

`default_nettype wire

[rtl/core/infix_expression_evaluator.sv]
// ----------------------------------------------------------------------------
// infix_expression_evaluator
// Two-level precedence integer expression evaluator, one operand/operator
// word at a time; emits the value on equals.
//
//   channel | valid        | stall        | payload
//   --------+--------------+--------------+----------------------------
//   in      | i_in_valid   | o_in_stall   | i_operand, i_opr
//   out     | o_out_valid  | i_out_stall  | o_value, o_div_zero
//
// A word runs one iteration per bit in the shared multiply/divide unit when a
// product or a quotient by a nonzero operand is pending.
// Synchronous active-low reset clears the expression state and the result-valid flag.
// A full, stalled result register holds an equals word in its final cycle;
// other words keep flowing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module infix_expression_evaluator #(
    parameter int DATA_WIDTH = 32
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_in_valid,
    output logic                                  o_in_stall,
    input  wire [iee_pkg::OPND_WIDTH-1:0]         i_operand,
    input  wire [2:0]                             i_opr,
    output logic                                  o_out_valid,
    input  wire                                   i_out_stall,
    output logic signed [iee_pkg::OUT_WIDTH-1:0]  o_value,
    output logic                                  o_div_zero
);
    import iee_pkg::*;

    t_iee_cmd cmd;
    t_iee_sts sts;

    iee_ctrl #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    iee_dpath #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_operand   (i_operand),
        .i_opr       (i_opr),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_value     (o_value),
        .o_div_zero  (o_div_zero)
    );

endmodule

`default_nettype wire

[test/tb_infix_expression_evaluator.sv]
// ----------------------------------------------------------------------------
// tb_infix_expression_evaluator
// Drives operand/operator words into the evaluator with random idle gaps on
// the input and random stalls on the output. A scoreboard tracks the sum,
// term, pending operation and divide-by-zero flag of the running expression,
// predicts the value on each equals word and checks every result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_infix_expression_evaluator;

    import iee_pkg::*;

    localparam logic [2:0] OPR_EQ   = 3'd4;
    localparam logic [2:0] OPR_LAST = 3'd7;
    localparam logic [OPND_WIDTH-1:0] OPND_MAX = '1;
    localparam int WORD_TARGET  = 1950;
    localparam int DRAIN_CYCLES = 2 * (32 + 3);

    class expr_scoreboard;
        logic [OUT_WIDTH-1:0] sum_q;
        logic [OUT_WIDTH-1:0] term_q;
        logic [1:0]           pend_q;
        logic                 err_q;
        logic [OUT_WIDTH-1:0] value_q[$];
        logic                 dz_q[$];
        int                   fails;

        function new();
            fails = 0;
            clear();
        endfunction

        function void clear();
            sum_q  = '0;
            term_q = '0;
            pend_q = PEND_POS;
            err_q  = 1'b0;
        endfunction

        function void note_word(logic [OPND_WIDTH-1:0] opnd, logic [2:0] opr);
            logic [OUT_WIDTH-1:0] x;
            logic [OUT_WIDTH-1:0] mag;
            logic [OUT_WIDTH-1:0] quo;
            x = {1'b0, opnd};
            case (pend_q)
                PEND_POS: term_q = x;
                PEND_NEG: term_q = -x;
                PEND_MUL: term_q = term_q * x;
                default: begin
                    if (x == '0) begin
                        err_q  = 1'b1;
                        term_q = '0;
                    end else begin
                        mag    = term_q[OUT_WIDTH-1] ? -term_q : term_q;
                        quo    = mag / x;
                        term_q = term_q[OUT_WIDTH-1] ? -quo : quo;
                    end
                end
            endcase
            case (opr)
                OPR_ADD: begin
                    sum_q  = sum_q + term_q;
                    pend_q = PEND_POS;
                end
                OPR_SUB: begin
                    sum_q  = sum_q + term_q;
                    pend_q = PEND_NEG;
                end
                OPR_MUL: pend_q = PEND_MUL;
                OPR_DIV: pend_q = PEND_DIV;
                default: begin
                    value_q.push_back(sum_q + term_q);
                    dz_q.push_back(err_q);
                    clear();
                end
            endcase
        endfunction

        function void check_result(logic [OUT_WIDTH-1:0] value, logic dz);
            logic [OUT_WIDTH-1:0] exp_value;
            logic                 exp_dz;
            if (value_q.size() == 0) begin
                $display("%0t: unexpected result value=%0d div_zero=%0b",
                         $time, $signed(value), dz);
                fails++;
                return;
            end
            exp_value = value_q.pop_front();
            exp_dz    = dz_q.pop_front();
            if (value !== exp_value) begin
                $display("%0t: value mismatch expected=%0d actual=%0d",
                         $time, $signed(exp_value), $signed(value));
                fails++;
            end
            if (dz !== exp_dz) begin
                $display("%0t: div_zero mismatch expected=%0b actual=%0b",
                         $time, exp_dz, dz);
                fails++;
            end
        endfunction

        function int outstanding();
            return value_q.size();
        endfunction
    endclass

    logic                         i_clk = 1'b0;
    logic                         i_rst_n;
    logic                         i_in_valid;
    logic                         o_in_stall;
    logic [OPND_WIDTH-1:0]        i_operand;
    logic [2:0]                   i_opr;
    logic                         o_out_valid;
    logic                         i_out_stall;
    logic signed [OUT_WIDTH-1:0]  o_value;
    logic                         o_div_zero;

    expr_scoreboard sb = new();
    int             words_sent = 0;
    logic           steady = 1'b0;

    infix_expression_evaluator #(
        .DATA_WIDTH(32)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_operand  (i_operand),
        .i_opr      (i_opr),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_value    (o_value),
        .o_div_zero (o_div_zero)
    );

    always #6 i_clk = ~i_clk;

    task automatic send_word(logic [OPND_WIDTH-1:0] opnd, logic [2:0] opr);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 18);
        repeat (gap + 1) @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_operand  <= opnd;
        i_opr      <= opr;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_word(opnd, opr);
        words_sent++;
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.outstanding() != 0) @(negedge i_clk);
    endtask

    function automatic logic [OPND_WIDTH-1:0] pick_operand();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return OPND_MAX;
            2, 3:    return OPND_WIDTH'($urandom_range(0, 15));
            4:       return OPND_WIDTH'($urandom_range(0, 65535));
            default: return OPND_WIDTH'($urandom());
        endcase
    endfunction

    // result side: stall a random stretch, mostly once a word shows up, then take it
    initial begin
        int n;
        i_out_stall = 1'b0;
        forever begin
            n = steady ? 0 : $urandom_range(0, 18);
            if (n != 0) begin
                i_out_stall <= 1'b1;
                if ($urandom_range(0, 3) != 0) begin
                    do @(posedge i_clk); while (!o_out_valid);
                end
                repeat (n) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_out_valid && i_rst_n));
            sb.check_result(o_value, o_div_zero);
            @(negedge i_clk);
        end
    end

    initial begin
        int len;
        bit drained_mid;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_operand  = '0;
        i_opr      = OPR_ADD;
        drained_mid = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_word(OPND_MAX, OPR_EQ);
        send_word('0, OPR_EQ);
        send_word(5, OPR_ADD);
        send_word(3, OPR_SUB);
        send_word(2, OPR_MUL);
        send_word(7, OPR_DIV);
        send_word(2, OPR_EQ);
        // divide by zero inside a term
        send_word(9, OPR_DIV);
        send_word('0, OPR_MUL);
        send_word(4, OPR_ADD);
        send_word(1, OPR_EQ);
        // most negative term divided
        send_word('0, OPR_SUB);
        send_word(OPND_WIDTH'(32'h4000_0000), OPR_MUL);
        send_word(2, OPR_DIV);
        send_word(3, OPR_EQ);
        // wrapping product and sum, unknown codes acting as equals
        send_word(OPND_MAX, OPR_MUL);
        send_word(OPND_MAX, OPR_ADD);
        send_word(OPND_MAX, OPR_EQ + 3'd1);
        send_word(1, OPR_SUB);
        send_word(OPND_MAX, OPR_SUB);
        send_word(OPND_MAX, OPR_LAST - 3'd1);
        send_word('0, OPR_LAST);

        wait_drained();

        while (words_sent < WORD_TARGET) begin
            if (!drained_mid && words_sent > WORD_TARGET / 2) begin
                drained_mid = 1'b1;
                wait_drained();
            end
            steady = ($urandom_range(0, 5) == 0);
            len = $urandom_range(1, 8);
            for (int k = 0; k < len; k++) begin
                if (k == len - 1) begin
                    send_word(pick_operand(), ($urandom_range(0, 7) == 0) ?
                              3'($urandom_range(OPR_EQ + 1, OPR_LAST)) : OPR_EQ);
                end else begin
                    send_word(pick_operand(), 3'($urandom_range(OPR_ADD, OPR_DIV)));
                end
            end
        end

        steady = 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.fails == 0) begin
            $display("tb_infix_expression_evaluator: PASS");
        end else begin
            $display("tb_infix_expression_evaluator: FAIL");
        end
        $finish;
    end

    initial begin
        #12_000_000;
        $display("tb_infix_expression_evaluator: FAIL");
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
+incdir+rtl/core
rtl/core/iee_pkg.sv
rtl/core/iee_ctrl.sv
rtl/core/iee_dpath.sv
rtl/core/infix_expression_evaluator.sv
test/tb_infix_expression_evaluator.sv
